FILE: sv/lpff_pkg.sv
// lpff_pkg: shared types, codes and constants for the length-prefixed frame fifo
// used by lpff_ctrl, lpff_datapath and length_prefixed_frame_fifo_core
`timescale 1ns / 1ps

package lpff_pkg;

    // default ring depth in bytes
    localparam int RING_DEPTH_DEF = 512;

    // frame header and minimum frame length
    localparam int HEADER_BYTES = 4;
    localparam int MIN_FRAME    = 7;

    // operation codes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POLL = 2'd1;
    localparam logic [1:0] OP_RECV = 2'd2;
    localparam logic [1:0] OP_RAW  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOT_RDY  = 3'd2;
    localparam logic [2:0] ST_FRM_RDY  = 3'd3;
    localparam logic [2:0] ST_CORRUPT  = 3'd4;
    localparam logic [2:0] ST_REJECTED = 3'd5;

    // input transaction payload
    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  byte_value;
        logic [15:0] limit;
    } lpff_in_t;

    // result transaction payload
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] data_bytes;
        logic [3:0]  byte_count;
        logic        last;
    } lpff_out_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       latch;
        logic       write;
        logic       hdr_rd;
        logic       hdr_cap;
        logic       load_raw;
        logic       load_hdr;
        logic       pop;
        logic       capture;
        logic       emit;
        logic [2:0] status;
        logic       last;
    } lpff_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       full;
        logic       fill_lt_hdr_bytes;
        logic       hdr_last;
        logic       hdr_lt_min;
        logic       hdr_gt_depth;
        logic       hdr_gt_limit;
        logic       fill_lt_hdr;
        logic       raw_zero;
        logic       rem_zero;
        logic       acc_seven;
        logic       out_free;
    } lpff_stat_t;

endpackage

FILE: sv/lpff_datapath.sv
// lpff_datapath: byte ring memory, pointers, fill count, header and output registers
// depends on lpff_pkg; driven by commands from lpff_ctrl
`timescale 1ns / 1ps

module lpff_datapath #(
    parameter int RING_DEPTH = lpff_pkg::RING_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lpff_pkg::lpff_in_t s_data,
    input  lpff_pkg::lpff_cmd_t cmd,
    output lpff_pkg::lpff_stat_t stat,
    input  logic               m_ready,
    output logic               m_valid,
    output lpff_pkg::lpff_out_t m_data
);
    import lpff_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(RING_DEPTH - 1);

    // byte ring
    logic [7:0] mem [RING_DEPTH];
    logic [7:0] rdata_reg;
    logic [PTR_W-1:0] raddr;

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    lpff_in_t         in_reg, in_next;
    logic [1:0]       hdr_idx_reg, hdr_idx_next;
    logic [31:0]      hdr_reg, hdr_next;
    logic [63:0]      acc_data_reg, acc_data_next;
    logic [3:0]       acc_cnt_reg, acc_cnt_next;
    logic             out_valid_reg, out_valid_next;
    lpff_out_t        out_reg, out_next;

    logic [PTR_W:0]   peek_sum;
    logic [PTR_W-1:0] peek_addr;
    logic             out_free;

    // header peek address, wrapped around the ring
    always_comb begin
        peek_sum = {1'b0, rd_ptr_reg} + {{(PTR_W - 1){1'b0}}, hdr_idx_reg};
        if (peek_sum >= (PTR_W + 1)'(RING_DEPTH)) begin
            peek_sum = peek_sum - (PTR_W + 1)'(RING_DEPTH);
        end
        peek_addr = peek_sum[PTR_W-1:0];
        raddr     = cmd.hdr_rd ? peek_addr : rd_ptr_reg;
    end

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[wr_ptr_reg] <= in_reg.byte_value;
        end
        rdata_reg <= mem[raddr];
    end

    assign out_free = !out_valid_reg || m_ready;

    // next-state logic for pointers, counters and holding registers
    always_comb begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        rem_next       = rem_reg;
        in_next        = in_reg;
        hdr_idx_next   = hdr_idx_reg;
        hdr_next       = hdr_reg;
        acc_data_next  = acc_data_reg;
        acc_cnt_next   = acc_cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (cmd.latch) begin
            in_next      = s_data;
            hdr_idx_next = 2'd0;
        end
        if (cmd.write) begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end
        if (cmd.hdr_cap) begin
            hdr_next[{hdr_idx_reg, 3'b000} +: 8] = rdata_reg;
            hdr_idx_next = hdr_idx_reg + 1'b1;
        end
        if (cmd.load_raw) begin
            if (32'(in_reg.limit) < 32'(fill_reg)) begin
                rem_next = in_reg.limit[CNT_W-1:0];
            end else begin
                rem_next = fill_reg;
            end
        end
        if (cmd.load_hdr) begin
            rem_next = hdr_reg[CNT_W-1:0];
        end
        if (cmd.pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
            rem_next    = rem_reg - 1'b1;
        end
        if (cmd.capture) begin
            acc_data_next[{acc_cnt_reg[2:0], 3'b000} +: 8] = rdata_reg;
            acc_cnt_next = acc_cnt_reg + 1'b1;
        end

        // output register
        if (cmd.emit) begin
            out_valid_next      = 1'b1;
            out_next.status     = cmd.status;
            out_next.data_bytes = acc_data_reg;
            out_next.byte_count = acc_cnt_reg;
            out_next.last       = cmd.last;
            acc_data_next       = '0;
            acc_cnt_next        = '0;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            acc_cnt_reg   <= '0;
            acc_data_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            acc_cnt_reg   <= acc_cnt_next;
            acc_data_reg  <= acc_data_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        in_reg      <= in_next;
        hdr_idx_reg <= hdr_idx_next;
        hdr_reg     <= hdr_next;
        out_reg     <= out_next;
    end

    // status towards the controller
    always_comb begin
        stat.opcode            = in_reg.opcode;
        stat.full              = (fill_reg == CNT_W'(RING_DEPTH));
        stat.fill_lt_hdr_bytes = (fill_reg < CNT_W'(HEADER_BYTES));
        stat.hdr_last          = (hdr_idx_reg == 2'd3);
        stat.hdr_lt_min        = (hdr_reg < 32'(MIN_FRAME));
        stat.hdr_gt_depth      = (hdr_reg > 32'(RING_DEPTH));
        stat.hdr_gt_limit      = (hdr_reg > 32'(in_reg.limit));
        stat.fill_lt_hdr       = (32'(fill_reg) < hdr_reg);
        stat.raw_zero          = (in_reg.limit == 16'd0) || (fill_reg == '0);
        stat.rem_zero          = (rem_reg == '0);
        stat.acc_seven         = (acc_cnt_reg == 4'd7);
        stat.out_free          = out_free;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: sv/lpff_ctrl.sv
// lpff_ctrl: controller state machine sequencing push, poll, receive and raw read
// depends on lpff_pkg; commands lpff_datapath
`timescale 1ns / 1ps

module lpff_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lpff_pkg::lpff_stat_t stat,
    output lpff_pkg::lpff_cmd_t  cmd
);
    import lpff_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_HDR_RD  = 3'd2;
    localparam logic [2:0] S_HDR_CAP = 3'd3;
    localparam logic [2:0] S_CHECK   = 3'd4;
    localparam logic [2:0] S_POP_RD  = 3'd5;
    localparam logic [2:0] S_POP_CAP = 3'd6;
    localparam logic [2:0] S_EMIT    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] status_reg, status_next;
    logic       last_reg, last_next;

    // sequencing
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        last_next   = last_reg;
        cmd         = '0;
        s_ready     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                last_next = 1'b1;
                unique case (stat.opcode)
                    OP_PUSH: begin
                        if (stat.full) begin
                            status_next = ST_FULL;
                        end else begin
                            cmd.write   = 1'b1;
                            status_next = ST_DONE;
                        end
                        state_next = S_EMIT;
                    end
                    OP_POLL, OP_RECV: begin
                        if (stat.fill_lt_hdr_bytes) begin
                            status_next = (stat.opcode == OP_POLL) ? ST_NOT_RDY
                                                                   : ST_REJECTED;
                            state_next  = S_EMIT;
                        end else begin
                            state_next = S_HDR_RD;
                        end
                    end
                    default: begin
                        cmd.load_raw = 1'b1;
                        status_next  = ST_DONE;
                        state_next   = stat.raw_zero ? S_EMIT : S_POP_RD;
                    end
                endcase
            end
            S_HDR_RD: begin
                cmd.hdr_rd = 1'b1;
                state_next = S_HDR_CAP;
            end
            S_HDR_CAP: begin
                cmd.hdr_cap = 1'b1;
                state_next  = stat.hdr_last ? S_CHECK : S_HDR_RD;
            end
            S_CHECK: begin
                last_next  = 1'b1;
                state_next = S_EMIT;
                if (stat.opcode == OP_POLL) begin
                    priority if (stat.hdr_lt_min || stat.hdr_gt_depth) begin
                        status_next = ST_CORRUPT;
                    end else if (stat.fill_lt_hdr) begin
                        status_next = ST_NOT_RDY;
                    end else begin
                        status_next = ST_FRM_RDY;
                    end
                end else if (stat.hdr_lt_min || stat.hdr_gt_limit || stat.fill_lt_hdr) begin
                    status_next = ST_REJECTED;
                end else begin
                    cmd.load_hdr = 1'b1;
                    status_next  = ST_DONE;
                    state_next   = S_POP_RD;
                end
            end
            S_POP_RD: begin
                cmd.pop    = 1'b1;
                state_next = S_POP_CAP;
            end
            S_POP_CAP: begin
                cmd.capture = 1'b1;
                if (stat.acc_seven || stat.rem_zero) begin
                    last_next  = stat.rem_zero;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_POP_RD;
                end
            end
            default: begin
                // S_EMIT: wait for a free output slot
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.status = status_reg;
                    cmd.last   = last_reg;
                    state_next = last_reg ? S_IDLE : S_POP_RD;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_DONE;
            last_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

endmodule

FILE: sv/length_prefixed_frame_fifo_core.sv
// Length-prefixed frame fifo: one transaction in flight; a push, and a poll or
// receive with under four bytes buffered, go straight to the result; other polls and
// receives read the four header bytes through one port before the header check.
// Pops then alternate a read and a capture state per byte, up to 8 bytes per result;
// a held result stalls the pop walk until the output register frees; reset (aresetn,
// synchronous, active low) clears pointers, fill count and control, not ring contents.
`timescale 1ns / 1ps

module length_prefixed_frame_fifo_core #(
    parameter int RING_DEPTH = lpff_pkg::RING_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lpff_pkg::lpff_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lpff_pkg::lpff_out_t m_data
);
    import lpff_pkg::*;

    lpff_cmd_t  cmd;
    lpff_stat_t stat;

    // controller
    lpff_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath
    lpff_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule
